// ===== rtl/core/qvr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quaternion vector rotation pipeline: widths, beat types and the
// inner product helper. Depends on nothing.
package qvr_pkg;

    localparam int VEC_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int VP_W       = VEC_W + QUAT_W;
    localparam int T_W        = VP_W + 1;
    localparam int TLO_W      = 25;
    localparam int THI_W      = T_W - TLO_W;
    localparam int PH_W       = QUAT_W + THI_W;
    localparam int PL_W       = QUAT_W + TLO_W + 1;
    localparam int PROD_W     = 65;
    localparam int FRAC_SHIFT = 27;
    localparam int DELTA_W    = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = DELTA_W + 1;
    localparam int AXES       = 3;

    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [VP_W-1:0]    vp_t;
    typedef logic signed [T_W-1:0]     tv_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        vec_t  vec_x;
        vec_t  vec_y;
        vec_t  vec_z;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        quat_t quat_w;
    } in_t;

    typedef struct packed {
        vec_t rot_x;
        vec_t rot_y;
        vec_t rot_z;
    } out_t;

    typedef struct packed {
        vec_t  vec_x;
        vec_t  vec_y;
        vec_t  vec_z;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        tv_t   t_x;
        tv_t   t_y;
        tv_t   t_z;
    } inner_t;

    typedef struct packed {
        vec_t   vec_x;
        vec_t   vec_y;
        vec_t   vec_z;
        delta_t delta_x;
        delta_t delta_y;
        delta_t delta_z;
    } outer_t;

    function automatic vp_t mul_qv(input quat_t q, input vec_t v);
        return VP_W'(q) * VP_W'(v);
    endfunction

endpackage

// ===== rtl/core/qvr_inner.sv =====
`timescale 1ns / 1ps
// Inner term t = cross(q, v) + w*v over two stages: products, then sums.
// Depends on qvr_pkg.
module qvr_inner (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qvr_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qvr_pkg::inner_t out_data
);
    import qvr_pkg::*;

    typedef struct packed {
        vec_t  vec_x;
        vec_t  vec_y;
        vec_t  vec_z;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        vp_t   qy_vz;
        vp_t   qz_vy;
        vp_t   qw_vx;
        vp_t   qz_vx;
        vp_t   qx_vz;
        vp_t   qw_vy;
        vp_t   qx_vy;
        vp_t   qy_vx;
        vp_t   qw_vz;
    } prod_t;

    logic   s1_valid_reg;
    logic   s2_valid_reg;
    logic   s1_adv;
    logic   s2_adv;
    prod_t  s1_reg;
    prod_t  s1_next;
    inner_t s2_reg;
    inner_t s2_next;

    assign s2_adv    = !s2_valid_reg || out_ready;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign in_ready  = s1_adv;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    always_comb
    begin
        s1_next.vec_x  = in_data.vec_x;
        s1_next.vec_y  = in_data.vec_y;
        s1_next.vec_z  = in_data.vec_z;
        s1_next.quat_x = in_data.quat_x;
        s1_next.quat_y = in_data.quat_y;
        s1_next.quat_z = in_data.quat_z;
        s1_next.qy_vz  = mul_qv(in_data.quat_y, in_data.vec_z);
        s1_next.qz_vy  = mul_qv(in_data.quat_z, in_data.vec_y);
        s1_next.qw_vx  = mul_qv(in_data.quat_w, in_data.vec_x);
        s1_next.qz_vx  = mul_qv(in_data.quat_z, in_data.vec_x);
        s1_next.qx_vz  = mul_qv(in_data.quat_x, in_data.vec_z);
        s1_next.qw_vy  = mul_qv(in_data.quat_w, in_data.vec_y);
        s1_next.qx_vy  = mul_qv(in_data.quat_x, in_data.vec_y);
        s1_next.qy_vx  = mul_qv(in_data.quat_y, in_data.vec_x);
        s1_next.qw_vz  = mul_qv(in_data.quat_w, in_data.vec_z);
    end

    always_comb
    begin
        s2_next.vec_x  = s1_reg.vec_x;
        s2_next.vec_y  = s1_reg.vec_y;
        s2_next.vec_z  = s1_reg.vec_z;
        s2_next.quat_x = s1_reg.quat_x;
        s2_next.quat_y = s1_reg.quat_y;
        s2_next.quat_z = s1_reg.quat_z;
        s2_next.t_x    = T_W'(s1_reg.qy_vz) - T_W'(s1_reg.qz_vy) + T_W'(s1_reg.qw_vx);
        s2_next.t_y    = T_W'(s1_reg.qz_vx) - T_W'(s1_reg.qx_vz) + T_W'(s1_reg.qw_vy);
        s2_next.t_z    = T_W'(s1_reg.qx_vy) - T_W'(s1_reg.qy_vx) + T_W'(s1_reg.qw_vz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

// ===== rtl/core/qvr_outer.sv =====
`timescale 1ns / 1ps
// Outer term floor(2*cross(q, t) / 2^28) over three stages: split products,
// recombination, difference and shift. Depends on qvr_pkg.
module qvr_outer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qvr_pkg::inner_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qvr_pkg::outer_t out_data
);
    import qvr_pkg::*;

    typedef logic signed [PH_W-1:0]   ph_t;
    typedef logic signed [PL_W-1:0]   pl_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    logic  s3_valid_reg;
    logic  s4_valid_reg;
    logic  s5_valid_reg;
    logic  s3_adv;
    logic  s4_adv;
    logic  s5_adv;

    quat_t qa [AXES];
    quat_t qb [AXES];
    tv_t   ta [AXES];
    tv_t   tb [AXES];
    vec_t  v_in [AXES];

    ph_t    ah_next [AXES];
    pl_t    al_next [AXES];
    ph_t    bh_next [AXES];
    pl_t    bl_next [AXES];
    ph_t    ah_reg [AXES];
    pl_t    al_reg [AXES];
    ph_t    bh_reg [AXES];
    pl_t    bl_reg [AXES];
    vec_t   v3_reg [AXES];
    prod_t  pa_next [AXES];
    prod_t  pb_next [AXES];
    prod_t  pa_reg [AXES];
    prod_t  pb_reg [AXES];
    vec_t   v4_reg [AXES];
    prod_t  diff [AXES];
    delta_t delta_next [AXES];
    delta_t delta_reg [AXES];
    vec_t   v5_reg [AXES];

    assign s5_adv    = !s5_valid_reg || out_ready;
    assign s4_adv    = !s4_valid_reg || s5_adv;
    assign s3_adv    = !s3_valid_reg || s4_adv;
    assign in_ready  = s3_adv;
    assign out_valid = s5_valid_reg;

    always_comb
    begin
        v_in[0] = in_data.vec_x;
        v_in[1] = in_data.vec_y;
        v_in[2] = in_data.vec_z;
        qa[0] = in_data.quat_y;
        tb[0] = in_data.t_z;
        qb[0] = in_data.quat_z;
        ta[0] = in_data.t_y;
        qa[1] = in_data.quat_z;
        tb[1] = in_data.t_x;
        qb[1] = in_data.quat_x;
        ta[1] = in_data.t_z;
        qa[2] = in_data.quat_x;
        tb[2] = in_data.t_y;
        qb[2] = in_data.quat_y;
        ta[2] = in_data.t_x;
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            ah_next[i] = PH_W'(qa[i]) * PH_W'($signed(tb[i][T_W-1:TLO_W]));
            al_next[i] = PL_W'(qa[i]) * PL_W'($signed({1'b0, tb[i][TLO_W-1:0]}));
            bh_next[i] = PH_W'(qb[i]) * PH_W'($signed(ta[i][T_W-1:TLO_W]));
            bl_next[i] = PL_W'(qb[i]) * PL_W'($signed({1'b0, ta[i][TLO_W-1:0]}));
            pa_next[i] = (PROD_W'(ah_reg[i]) <<< TLO_W) + PROD_W'(al_reg[i]);
            pb_next[i] = (PROD_W'(bh_reg[i]) <<< TLO_W) + PROD_W'(bl_reg[i]);
            diff[i]       = pa_reg[i] - pb_reg[i];
            delta_next[i] = $signed(diff[i][PROD_W-1:FRAC_SHIFT]);
        end
    end

    always_comb
    begin
        out_data.vec_x   = v5_reg[0];
        out_data.vec_y   = v5_reg[1];
        out_data.vec_z   = v5_reg[2];
        out_data.delta_x = delta_reg[0];
        out_data.delta_y = delta_reg[1];
        out_data.delta_z = delta_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_adv)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_adv)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (s3_adv && in_valid)
            begin
                ah_reg[i] <= ah_next[i];
                al_reg[i] <= al_next[i];
                bh_reg[i] <= bh_next[i];
                bl_reg[i] <= bl_next[i];
                v3_reg[i] <= v_in[i];
            end
            if (s4_adv && s3_valid_reg)
            begin
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
                v4_reg[i] <= v3_reg[i];
            end
            if (s5_adv && s4_valid_reg)
            begin
                delta_reg[i] <= delta_next[i];
                v5_reg[i]    <= v4_reg[i];
            end
        end
    end

endmodule

// ===== rtl/core/qvr_sat.sv =====
`timescale 1ns / 1ps
// Final stage: add the outer term to the vector and saturate to Q16.16.
// Depends on qvr_pkg.
module qvr_sat (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qvr_pkg::outer_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qvr_pkg::out_t   out_data
);
    import qvr_pkg::*;

    typedef logic signed [SUM_W-1:0] sum_t;

    logic s6_valid_reg;
    logic s6_adv;
    out_t s6_reg;
    out_t s6_next;

    function automatic vec_t sat_add(input vec_t v, input delta_t d);
        sum_t s;
        s = SUM_W'(v) + SUM_W'(d);
        if (s[SUM_W-1:VEC_W-1] == {(SUM_W-VEC_W+1){s[SUM_W-1]}})
        begin
            return s[VEC_W-1:0];
        end
        else if (s[SUM_W-1])
        begin
            return {1'b1, {(VEC_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(VEC_W-1){1'b1}}};
        end
    endfunction

    assign s6_adv    = !s6_valid_reg || out_ready;
    assign in_ready  = s6_adv;
    assign out_valid = s6_valid_reg;
    assign out_data  = s6_reg;

    always_comb
    begin
        s6_next.rot_x = sat_add(in_data.vec_x, in_data.delta_x);
        s6_next.rot_y = sat_add(in_data.vec_y, in_data.delta_y);
        s6_next.rot_z = sat_add(in_data.vec_z, in_data.delta_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (s6_adv)
        begin
            s6_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_adv && in_valid)
        begin
            s6_reg <= s6_next;
        end
    end

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// Top level of the quaternion vector rotation pipeline.
// Depends on qvr_pkg, qvr_inner, qvr_outer and qvr_sat.
//
//   channel | handshake            | beat
//   --------+----------------------+---------------------------------
//   in      | in_valid / in_ready  | in_data  (vector, quaternion)
//   out     | out_valid / out_ready| out_data (rotated vector)
//
// Six register stages: two for the inner term, three for the outer term,
// one for the add and saturate. One beat per cycle while the output is not stalled.
// Each stage holds its own valid bit and moves when the stage after it is
// free, so a stalled output fills bubbles before in_ready drops.
// Reset clears the valid bits only.
module quaternion_vector_rotate (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qvr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output qvr_pkg::out_t out_data
);
    import qvr_pkg::*;

    logic   inner_valid;
    logic   inner_ready;
    inner_t inner_data;
    logic   outer_valid;
    logic   outer_ready;
    outer_t outer_data;

    qvr_inner u_inner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (inner_valid),
        .out_ready (inner_ready),
        .out_data  (inner_data)
    );

    qvr_outer u_outer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (inner_valid),
        .in_ready  (inner_ready),
        .in_data   (inner_data),
        .out_valid (outer_valid),
        .out_ready (outer_ready),
        .out_data  (outer_data)
    );

    qvr_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (outer_valid),
        .in_ready  (outer_ready),
        .in_data   (outer_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/qvr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for quaternion_vector_rotate, attached by bind.
// Depends on qvr_pkg.
module qvr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input qvr_pkg::out_t out_data
);
    import qvr_pkg::*;

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // drop all beats on reset
    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

    // refuse input only when the output is stalled with a full pipe
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output stall");

    // advance an accepted beat to the output when never stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_beat, 6) && $past(rst_n, 6)
        && $past(rst_n && out_ready, 1) && $past(rst_n && out_ready, 2)
        && $past(rst_n && out_ready, 3) && $past(rst_n && out_ready, 4)
        && $past(rst_n && out_ready, 5) |-> out_valid)
        else $error("accepted beat did not reach the output in six cycles");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

// ===== tb/quaternion_vector_rotate_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quaternion_vector_rotate: streams vector and quaternion beats,
// predicts each rotated vector in exact wide arithmetic and compares every output beat.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module quaternion_vector_rotate_test;

    localparam int          DROP_BITS   = 27;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic signed [95:0] Q16_MAX = 96'sd2147483647;
    localparam logic signed [95:0] Q16_MIN = -96'sd2147483648;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    qvr_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    qvr_pkg::out_t out_data;

    qvr_pkg::out_t pending_rotations[$];
    int            fail_count = 0;
    int            in_idle_pct = 33;
    int            out_idle_pct = 33;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    int unsigned   cycle_count = 0;

    quaternion_vector_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic qvr_pkg::vec_t saturate_q16(input logic signed [95:0] s);
        if (s > Q16_MAX)
            return qvr_pkg::vec_t'(Q16_MAX);
        if (s < Q16_MIN)
            return qvr_pkg::vec_t'(Q16_MIN);
        return qvr_pkg::vec_t'(s);
    endfunction

    function automatic qvr_pkg::out_t rotate_expected(input qvr_pkg::in_t b);
        logic signed [95:0] vx, vy, vz, qx, qy, qz, qw;
        logic signed [95:0] tx, ty, tz, dx, dy, dz;
        qvr_pkg::out_t      r;
        vx = $signed(b.vec_x);
        vy = $signed(b.vec_y);
        vz = $signed(b.vec_z);
        qx = $signed(b.quat_x);
        qy = $signed(b.quat_y);
        qz = $signed(b.quat_z);
        qw = $signed(b.quat_w);
        // inner term carries 30 fraction bits, outer product 44
        tx = qy * vz - qz * vy + qw * vx;
        ty = qz * vx - qx * vz + qw * vy;
        tz = qx * vy - qy * vx + qw * vz;
        // doubling and dropping 28 bits is a floor shift by 27
        dx = (qy * tz - qz * ty) >>> DROP_BITS;
        dy = (qz * tx - qx * tz) >>> DROP_BITS;
        dz = (qx * ty - qy * tx) >>> DROP_BITS;
        r.rot_x = saturate_q16(vx + dx);
        r.rot_y = saturate_q16(vy + dy);
        r.rot_z = saturate_q16(vz + dz);
        return r;
    endfunction

    function automatic qvr_pkg::vec_t pick_vec();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return qvr_pkg::vec_t'(32'h7FFF_FFFF);
        if (sel < 8)
            return qvr_pkg::vec_t'(32'h8000_0000);
        if (sel < 11)
            return qvr_pkg::vec_t'(-1);
        if (sel < 14)
            return '0;
        if (sel < 50)
            return qvr_pkg::vec_t'($urandom);
        return qvr_pkg::vec_t'($urandom) >>> $urandom_range(4, 30);
    endfunction

    function automatic qvr_pkg::quat_t pick_quat();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return qvr_pkg::quat_t'(16'h7FFF);
        if (sel < 8)
            return qvr_pkg::quat_t'(16'h8000);
        if (sel < 12)
            return '0;
        if (sel < 45)
            return qvr_pkg::quat_t'($urandom);
        // near-unit range keeps most results clear of saturation
        return qvr_pkg::quat_t'($urandom_range(0, 32768)) - qvr_pkg::quat_t'(16384);
    endfunction

    function automatic qvr_pkg::in_t random_beat();
        qvr_pkg::in_t b;
        b.vec_x  = pick_vec();
        b.vec_y  = pick_vec();
        b.vec_z  = pick_vec();
        b.quat_x = pick_quat();
        b.quat_y = pick_quat();
        b.quat_z = pick_quat();
        b.quat_w = pick_quat();
        return b;
    endfunction

    function automatic qvr_pkg::in_t make_beat(input int vx, input int vy, input int vz,
                                               input shortint qx, input shortint qy,
                                               input shortint qz, input shortint qw);
        qvr_pkg::in_t b;
        b.vec_x  = vx;
        b.vec_y  = vy;
        b.vec_z  = vz;
        b.quat_x = qx;
        b.quat_y = qy;
        b.quat_z = qz;
        b.quat_w = qw;
        return b;
    endfunction

    task automatic check_field(input string name, input qvr_pkg::vec_t want,
                               input qvr_pkg::vec_t got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count < 60)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic send_beat(input qvr_pkg::in_t b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rotations.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_beat(make_beat(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 16384));
        send_beat(make_beat(32'h7FFF_FFFF, 32'h8000_0000, 12345, 0, 0, 0, 0));
        send_beat(make_beat(32'h0001_0000, 0, 0, 0, 0, 11585, 11585));
        send_beat(make_beat(0, 32'h0001_0000, 0, 11585, 0, 0, 11585));
        send_beat(make_beat(0, 0, 32'h0001_0000, 0, 11585, 0, 11585));
        send_beat(make_beat(32'h0003_0000, -32'sh0005_0000, 32'h0007_0000, 16384, 0, 0, 0));
        send_beat(make_beat(32'h0001_0000, -32'sh0001_0000, 1, 0, 0, 0, 32767));
        send_beat(make_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32767, 32767, 32767, 32767));
        send_beat(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            -32768, -32768, -32768, -32768));
        send_beat(make_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            -32768, 32767, -32768, 32767));
        send_beat(make_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32767, -32768, 32767, -32768));
        send_beat(make_beat(-1, -1, -1, -1, -1, -1, -1));
        send_beat(make_beat(1, 1, 1, 1, -1, 1, -1));
        send_beat(make_beat(0, 0, 0, 32767, 32767, 32767, 32767));
        send_beat(make_beat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, -32768, 0, 0, 0));
        send_beat(make_beat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, -32768, 0, 0));
        send_beat(make_beat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, -32768, 0));
        send_beat(make_beat(32'h2000_0000, -32'sh2000_0000, 32'h1FFF_FFFF, 0, 0, 0, -32768));
        send_beat(make_beat(32'h1234_5678, -32'sh0ABC_DEF0, 32'h00FF_00FF, 100, 200, 300, 16380));
        send_beat(make_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556));
        wait_drained();
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++)
            send_beat(random_beat());
    endtask

    task automatic test_no_idle_stretch(input int count);
        in_idle_pct = 0;
        out_idle_pct <= 0;
        test_random_stream(count);
        in_idle_pct = 33;
        out_idle_pct <= 33;
    endtask

    task automatic test_output_hold(input int count);
        in_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        test_random_stream(count);
        in_idle_pct = 33;
    endtask

    task automatic test_drain_pauses(input int bursts, input int count);
        for (int i = 0; i < bursts; i++)
        begin
            test_random_stream(count);
            wait_drained();
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin : check_beat
        qvr_pkg::out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_rotations.push_back(rotate_expected(in_data));
            if (out_valid && out_ready)
            begin
                if (pending_rotations.size() == 0)
                begin
                    fail_count++;
                    if (fail_count < 60)
                        $display("%0t: expected no beat, actual %h", $time, out_data);
                end
                else
                begin
                    want = pending_rotations.pop_front();
                    check_field("rot_x", want.rot_x, out_data.rot_x);
                    check_field("rot_y", want.rot_y, out_data.rot_y);
                    check_field("rot_z", want.rot_z, out_data.rot_z);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(900);
        test_no_idle_stretch(350);
        test_output_hold(80);
        test_drain_pauses(4, 60);
        test_random_stream(270);
        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_rotations.size() != 0)
        begin
            fail_count++;
            $display("%0t: expected %0d more beats, actual none", $time,
                     pending_rotations.size());
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
